>>> design/arcade_bus_decoder_io_defines.svh
// Assertion macros used by abdio_ctrl.
`ifndef ARCADE_BUS_DECODER_IO_DEFINES_SVH
`define ARCADE_BUS_DECODER_IO_DEFINES_SVH

`ifndef SYNTHESIS

`define ABDIO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ABDIO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define ABDIO_ASSERT(lbl, prop, msg)

`define ABDIO_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> design/abdio_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abdio_pkg;

  localparam int unsigned MainDepth  = 4096;
  localparam int unsigned ExtraDepth = 1024;
  localparam int unsigned MainAw     = $clog2(MainDepth);
  localparam int unsigned ExtraAw    = $clog2(ExtraDepth);

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [15:0] ADDR_JOY      = 16'h5000;
  localparam logic [15:0] ADDR_START    = 16'h5040;
  localparam logic [15:0] ADDR_SPR_LO   = 16'h5050;
  localparam logic [15:0] ADDR_SPR_HI   = 16'h505f;
  localparam logic [15:0] ADDR_SND_HI   = 16'h506f;
  localparam logic [15:0] ADDR_DIP      = 16'h5080;
  localparam logic [15:0] ADDR_PRIZE    = 16'h50c0;
  localparam logic [15:0] ADDR_FLIP     = 16'h50c1;
  localparam logic [15:0] ADDR_IRQ_EN   = 16'h50c2;

  localparam logic [4:0] LampThreshold = 5'd24;

  typedef struct packed {
    logic clear;
    logic capture;
    logic commit;
  } abdio_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } abdio_sts_t;

endpackage

`default_nettype wire

>>> design/abdio_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module abdio_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/abdio_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "arcade_bus_decoder_io_defines.svh"

module abdio_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire abdio_pkg::abdio_sts_t sts_i,
  output abdio_pkg::abdio_cmd_t    cmd_o
);
  import abdio_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `ABDIO_ASSERT(a_accept_then_busy, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  `ABDIO_ASSERT(a_commit_then_idle, cmd_o.commit |=> (state_q == ST_IDLE), "commit not to idle")
  `ABDIO_ASSERT_ALWAYS(a_clear_alone, !(cmd_o.clear && (cmd_o.capture || cmd_o.commit)), "clear overlap")

endmodule

`default_nettype wire

>>> design/abdio_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module abdio_dpath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire abdio_pkg::abdio_cmd_t cmd_i,
  output abdio_pkg::abdio_sts_t      sts_o,
  input  wire logic                  dip_we_i,
  input  wire logic [7:0]            dip_wdata_i,
  input  wire logic [1:0]            action_i,
  input  wire logic [15:0]           address_i,
  input  wire logic [7:0]            write_data_i,
  input  wire logic [7:0]            rom_data_i,
  input  wire logic [6:0]            buttons_i,
  input  wire logic [3:0]            random_nibble_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 read_data_o,
  output logic                       irq_request_o,
  output logic                       flip_state_o,
  output logic                       clock_shown_o,
  output logic [4:0]                 clock_value_o,
  output logic                       sound_written_o,
  output logic [4:0]                 sound_index_o,
  output logic [3:0]                 sound_value_o
);
  import abdio_pkg::*;

  logic [MainAw-1:0] clr_q;
  logic [1:0]  action_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q, rom_q;
  logic [6:0]  btn_q;
  logic [3:0]  rnd_q;
  logic [7:0]  dip_q;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [5:0]  pre_q, pre_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        flip_q, flip_d, irqen_q, irqen_d;
  logic        out_valid_q;

  logic [7:0]  main_rdata, extra_rdata;
  logic [MainAw-1:0]  main_addr;
  logic [ExtraAw-1:0] extra_addr;
  logic        main_we, extra_we;
  logic [7:0]  ram_wdata;

  logic is_read, is_write, is_tick;
  logic is_rom, is_main, is_extra, is_sprite, is_sound;
  logic wr_main, wr_extra, wr_sound;
  logic [7:0] rd, snd_off;
  logic irq;

  assign is_read  = (action_q == ACT_READ);
  assign is_write = (action_q == ACT_WRITE);
  assign is_tick  = (action_q == ACT_TICK);

  assign is_rom    = (addr_q[15:14] == 2'b00) || (addr_q[15:12] == 4'h8) ||
                     (addr_q[15:13] == 3'b101);
  assign is_main   = addr_q[14] && !addr_q[12];
  assign is_extra  = (addr_q[15:10] == 6'b100100);
  assign is_sprite = (addr_q >= ADDR_SPR_LO) && (addr_q <= ADDR_SPR_HI);
  assign is_sound  = (addr_q >= ADDR_START) && (addr_q <= ADDR_SND_HI);

  assign wr_main  = is_write && is_main;
  assign wr_extra = is_write && !is_main && (is_extra || is_sprite);
  assign wr_sound = is_write && !is_main && !is_extra && !is_sprite && is_sound;
  assign snd_off  = addr_q[7:0] - ADDR_START[7:0];

  always_comb begin
    rd = 8'h00;
    if (is_read) begin
      if (is_rom) begin
        rd = rom_q;
      end else if (is_main) begin
        rd = main_rdata;
      end else if (is_extra) begin
        rd = extra_rdata;
      end else if (addr_q == ADDR_JOY) begin
        rd = {1'b1, ~btn_q[5], ~btn_q[4], 1'b1, ~btn_q[3:0]};
      end else if (addr_q == ADDR_START) begin
        rd = btn_q[6] ? 8'hdf : 8'hff;
      end else if (addr_q == ADDR_DIP) begin
        rd = dip_q;
      end else if (addr_q == ADDR_PRIZE) begin
        rd = {4'h0, rnd_q};
      end else if (addr_q == ADDR_FLIP) begin
        rd = {7'd0, (cnt_q >= LampThreshold)};
      end else begin
        rd = 8'hff;
      end
    end
  end

  always_comb begin
    ctrl_d  = ctrl_q;
    pre_d   = pre_q;
    cnt_d   = cnt_q;
    flip_d  = flip_q;
    irqen_d = irqen_q;
    irq     = 1'b0;
    if (is_write && !is_main && !is_extra && !is_sprite && !is_sound) begin
      if (addr_q == ADDR_DIP) begin
        if (ctrl_q[0] != wdata_q[0]) begin
          pre_d = '0;
          cnt_d = '0;
        end
        ctrl_d = wdata_q;
      end else if (addr_q == ADDR_FLIP) begin
        flip_d = wdata_q[0];
      end else if (addr_q == ADDR_IRQ_EN) begin
        irqen_d = wdata_q[0];
      end
    end
    if (is_tick) begin
      pre_d = pre_q + 6'd1;
      if ((pre_d == 6'd0) && ctrl_q[0]) begin
        cnt_d = cnt_q + 5'd1;
      end
      irq = irqen_q;
    end
  end

  assign main_addr  = cmd_i.clear ? clr_q :
                      (cmd_i.capture ? address_i[MainAw-1:0] : addr_q[MainAw-1:0]);
  assign extra_addr = cmd_i.clear ? clr_q[ExtraAw-1:0] :
                      (cmd_i.capture ? address_i[ExtraAw-1:0] : addr_q[ExtraAw-1:0]);
  assign ram_wdata  = cmd_i.clear ? 8'h00 : wdata_q;
  assign main_we    = cmd_i.clear || (cmd_i.commit && wr_main);
  assign extra_we   = cmd_i.clear || (cmd_i.commit && wr_extra);

  abdio_ram #(.Width(8), .Depth(MainDepth)) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .re_i    (cmd_i.capture),
    .addr_i  (main_addr),
    .wdata_i (ram_wdata),
    .rdata_o (main_rdata)
  );

  abdio_ram #(.Width(8), .Depth(ExtraDepth)) u_extra_ram (
    .clk_i   (clk_i),
    .we_i    (extra_we),
    .re_i    (cmd_i.capture),
    .addr_i  (extra_addr),
    .wdata_i (ram_wdata),
    .rdata_o (extra_rdata)
  );

  assign sts_o.clear_last = (clr_q == MainAw'(MainDepth - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      dip_q       <= '0;
      ctrl_q      <= '0;
      pre_q       <= '0;
      cnt_q       <= '0;
      flip_q      <= 1'b0;
      irqen_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + 1'b1;
      end
      if (dip_we_i) begin
        dip_q <= dip_wdata_i;
      end
      if (cmd_i.commit) begin
        ctrl_q      <= ctrl_d;
        pre_q       <= pre_d;
        cnt_q       <= cnt_d;
        flip_q      <= flip_d;
        irqen_q     <= irqen_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      addr_q   <= address_i;
      wdata_q  <= write_data_i;
      rom_q    <= rom_data_i;
      btn_q    <= buttons_i;
      rnd_q    <= random_nibble_i;
    end
    if (cmd_i.commit) begin
      read_data_o     <= rd;
      irq_request_o   <= irq;
      flip_state_o    <= flip_d;
      clock_shown_o   <= ctrl_d[1];
      clock_value_o   <= cnt_d;
      sound_written_o <= wr_sound;
      sound_index_o   <= wr_sound ? {snd_off[5], snd_off[3:0]} : 5'd0;
      sound_value_o   <= wr_sound ? wdata_q[3:0] : 4'd0;
    end
  end

endmodule

`default_nettype wire

>>> design/arcade_bus_decoder_io.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   action, address, write data, ROM data,
//                                                buttons, random nibble
// out       output     out_valid_o / out_ready_i read data, irq, flip, clock, sound
// dip       input      dip_we_i                  dip_wdata_i
// Accepting an item starts the RAM read; the item is then decoded and its result is
// committed into the output register.
// After reset a clearing pass runs through all 4096 main RAM addresses and zeroes both
// RAMs; no item is accepted then. A new item is accepted while the previous result
// waits; it stalls in its commit cycle until the output register is free.

module arcade_bus_decoder_io (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        dip_we_i,
  input  wire logic [7:0]  dip_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [7:0]  rom_data_i,
  input  wire logic [6:0]  buttons_i,
  input  wire logic [3:0]  random_nibble_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o,
  output logic             irq_request_o,
  output logic             flip_state_o,
  output logic             clock_shown_o,
  output logic [4:0]       clock_value_o,
  output logic             sound_written_o,
  output logic [4:0]       sound_index_o,
  output logic [3:0]       sound_value_o
);
  import abdio_pkg::*;

  abdio_cmd_t cmd;
  abdio_sts_t sts;

  abdio_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  abdio_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .dip_we_i        (dip_we_i),
    .dip_wdata_i     (dip_wdata_i),
    .action_i        (action_i),
    .address_i       (address_i),
    .write_data_i    (write_data_i),
    .rom_data_i      (rom_data_i),
    .buttons_i       (buttons_i),
    .random_nibble_i (random_nibble_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_data_o     (read_data_o),
    .irq_request_o   (irq_request_o),
    .flip_state_o    (flip_state_o),
    .clock_shown_o   (clock_shown_o),
    .clock_value_o   (clock_value_o),
    .sound_written_o (sound_written_o),
    .sound_index_o   (sound_index_o),
    .sound_value_o   (sound_value_o)
  );

endmodule

`default_nettype wire

>>> verif/arcade_bus_decoder_io_test.sv
`timescale 1ns / 1ps

module arcade_bus_decoder_io_test;
  import abdio_pkg::*;

  localparam logic [1:0] ACT_IDLE = 2'd3;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  rom_data;
    logic [6:0]  buttons;
    logic [3:0]  random_nibble;
  } bus_access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
    logic       flip_state;
    logic       clock_shown;
    logic [4:0] clock_value;
    logic       sound_written;
    logic [4:0] sound_index;
    logic [3:0] sound_value;
  } bus_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic dip_we = 1'b0;
  logic [7:0] dip_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  bus_access_t offered = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bus_result_t observed;

  bus_access_t access_queue[$];
  bus_result_t expected_results[$];
  int unsigned mismatches = 0;

  logic [7:0] main_mem [MainDepth];
  logic [7:0] extra_mem [ExtraDepth];
  logic [3:0] sound_regs [32];
  logic [7:0] mystery_ctrl_q;
  logic [5:0] prescaler_q;
  logic [4:0] mystery_clock_q;
  logic       flip_q;
  logic       irq_en_q;
  logic [7:0] dip_setting;

  arcade_bus_decoder_io u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dip_we_i        (dip_we),
    .dip_wdata_i     (dip_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .action_i        (offered.action),
    .address_i       (offered.address),
    .write_data_i    (offered.write_data),
    .rom_data_i      (offered.rom_data),
    .buttons_i       (offered.buttons),
    .random_nibble_i (offered.random_nibble),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .read_data_o     (observed.read_data),
    .irq_request_o   (observed.irq_request),
    .flip_state_o    (observed.flip_state),
    .clock_shown_o   (observed.clock_shown),
    .clock_value_o   (observed.clock_value),
    .sound_written_o (observed.sound_written),
    .sound_index_o   (observed.sound_index),
    .sound_value_o   (observed.sound_value)
  );

  initial forever #5 clk_i = ~clk_i;

  // Applies one bus access to the shadow state and returns the result the block owes for it.
  function automatic bus_result_t decode_access(bus_access_t acc);
    bus_result_t res;
    logic [15:0] a;
    logic [5:0] off;
    logic [6:0] b;
    res = '0;
    a = acc.address;
    b = acc.buttons;
    case (acc.action)
      ACT_READ: begin
        if (a < 16'h4000 || (a >= 16'h8000 && a <= 16'h8fff) ||
            (a >= 16'ha000 && a <= 16'hbfff)) res.read_data = acc.rom_data;
        else if ((a & 16'h5000) == 16'h4000) res.read_data = main_mem[a[11:0]];
        else if ((a & 16'hfc00) == 16'h9000) res.read_data = extra_mem[a[9:0]];
        else if (a == ADDR_JOY) res.read_data = ~{1'b0, b[5], b[4], 1'b0, b[3:0]};
        else if (a == ADDR_START) res.read_data = b[6] ? 8'hdf : 8'hff;
        else if (a == ADDR_DIP) res.read_data = dip_setting;
        else if (a == ADDR_PRIZE) res.read_data = {4'h0, acc.random_nibble};
        else if (a == ADDR_FLIP) res.read_data = {7'd0, mystery_clock_q >= LampThreshold};
        else res.read_data = 8'hff;
      end
      ACT_WRITE: begin
        if ((a & 16'h5000) == 16'h4000) begin
          main_mem[a[11:0]] = acc.write_data;
        end else if ((a & 16'hfc00) == 16'h9000) begin
          extra_mem[a[9:0]] = acc.write_data;
        end else if (a >= ADDR_SPR_LO && a <= ADDR_SPR_HI) begin
          extra_mem[10'(a - ADDR_JOY)] = acc.write_data;
        end else if (a >= ADDR_START && a <= ADDR_SND_HI) begin
          off = 6'(a - ADDR_START);
          res.sound_written = 1'b1;
          res.sound_index = {off[5], off[3:0]};
          res.sound_value = acc.write_data[3:0];
          sound_regs[res.sound_index] = res.sound_value;
        end else if (a == ADDR_DIP) begin
          if (mystery_ctrl_q[0] != acc.write_data[0]) begin
            prescaler_q = '0;
            mystery_clock_q = '0;
          end
          mystery_ctrl_q = acc.write_data;
        end else if (a == ADDR_FLIP) begin
          flip_q = acc.write_data[0];
        end else if (a == ADDR_IRQ_EN) begin
          irq_en_q = acc.write_data[0];
        end
      end
      ACT_TICK: begin
        prescaler_q = prescaler_q + 6'd1;
        if (prescaler_q == '0 && mystery_ctrl_q[0]) mystery_clock_q = mystery_clock_q + 5'd1;
        res.irq_request = irq_en_q;
      end
      default: ;
    endcase
    res.flip_state = flip_q;
    res.clock_shown = mystery_ctrl_q[1];
    res.clock_value = mystery_clock_q;
    return res;
  endfunction

  // In a clock run the mystery control register is left alone so the clock keeps
  // counting; otherwise accesses spread over every decoded region.
  function automatic bus_access_t random_access(bit clock_run);
    bus_access_t acc;
    int unsigned pick;
    logic [11:0] main_off;
    logic [9:0] extra_off;
    acc.write_data = 8'($urandom);
    acc.rom_data = 8'($urandom);
    acc.buttons = 7'($urandom);
    acc.random_nibble = 4'($urandom);
    main_off = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 31));
    extra_off = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(64, 111));
    acc.address = {1'($urandom), 1'b1, 1'($urandom), 1'b0, main_off};
    pick = $urandom_range(0, 99);
    if (clock_run) begin
      if (pick < 88) begin
        acc.action = ACT_TICK;
      end else if (pick < 94) begin
        acc.action = ACT_READ;
        acc.address = ADDR_FLIP;
      end else begin
        acc.action = (pick < 97) ? ACT_READ : ACT_WRITE;
      end
      return acc;
    end
    if (pick < 45) acc.action = ACT_READ;
    else if (pick < 88) acc.action = ACT_WRITE;
    else if (pick < 96) acc.action = ACT_TICK;
    else acc.action = ACT_IDLE;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0: acc.address = 16'($urandom_range(0, 16'h3fff));
          1: acc.address = {4'h8, 12'($urandom)};
          default: acc.address = {3'b101, 13'($urandom)};
        endcase
      end
      1, 2: ;
      3: acc.address = {6'b100100, extra_off};
      4: acc.address = ADDR_SPR_LO + 16'($urandom_range(0, 15));
      5: acc.address = ADDR_START + 16'($urandom_range(0, 16'h2f));
      6: begin
        case ($urandom_range(0, 6))
          0: acc.address = ADDR_JOY;
          1: acc.address = ADDR_START;
          2: acc.address = ADDR_DIP;
          3: acc.address = ADDR_PRIZE;
          4: acc.address = ADDR_FLIP;
          5: acc.address = ADDR_IRQ_EN;
          default: acc.address = ADDR_PRIZE + 16'($urandom_range(3, 7));
        endcase
      end
      7: acc.address = ADDR_JOY | 16'($urandom_range(0, 255));
      default: acc.address = 16'($urandom);
    endcase
    return acc;
  endfunction

  task automatic queue_access(logic [1:0] act, logic [15:0] addr, logic [7:0] data,
                              logic [7:0] rom, logic [6:0] btn, logic [3:0] nib);
    access_queue.push_back('{act, addr, data, rom, btn, nib});
  endtask

  task automatic wait_drain();
    while (access_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic apply_dip(logic [7:0] value);
    @(posedge clk_i);
    dip_we <= 1'b1;
    dip_wdata <= value;
    dip_setting = value;
    @(posedge clk_i);
    dip_we <= 1'b0;
  endtask

  bit hold_request = 1'b0;

  initial begin : stimulus
    foreach (main_mem[i]) main_mem[i] = '0;
    foreach (extra_mem[i]) extra_mem[i] = '0;
    foreach (sound_regs[i]) sound_regs[i] = '0;
    mystery_ctrl_q = '0;
    prescaler_q = '0;
    mystery_clock_q = '0;
    flip_q = 1'b0;
    irq_en_q = 1'b0;
    dip_setting = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_access(ACT_READ, 16'h0000, 8'h00, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_READ, 16'h8fff, 8'h00, 8'ha5, 7'h00, 4'h0);
    queue_access(ACT_READ, 16'hbfff, 8'h00, 8'hff, 7'h00, 4'h0);
    queue_access(ACT_READ, 16'h4123, 8'h00, 8'h11, 7'h00, 4'h0);
    queue_access(ACT_WRITE, 16'h4000, 8'hff, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_READ, 16'he000, 8'h00, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_WRITE, 16'h93ff, 8'h81, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_READ, 16'h93ff, 8'h00, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_READ, 16'h9400, 8'h00, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_WRITE, ADDR_SPR_LO, 8'h3c, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_WRITE, ADDR_SPR_HI, 8'hc3, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_READ, 16'h905f, 8'h00, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_WRITE, ADDR_START, 8'hff, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_WRITE, ADDR_SND_HI, 8'h07, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_WRITE, ADDR_SND_HI, 8'h07, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_READ, ADDR_JOY, 8'h00, 8'h00, 7'h7f, 4'h0);
    queue_access(ACT_READ, ADDR_JOY, 8'h00, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_READ, ADDR_START, 8'h00, 8'h00, 7'h40, 4'h0);
    queue_access(ACT_READ, ADDR_DIP, 8'h00, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_READ, ADDR_PRIZE, 8'h00, 8'h00, 7'h00, 4'hf);
    queue_access(ACT_READ, ADDR_FLIP, 8'h00, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_WRITE, ADDR_FLIP, 8'h01, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_WRITE, ADDR_IRQ_EN, 8'hff, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_TICK, 16'h0000, 8'h00, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_WRITE, ADDR_DIP, 8'h03, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_WRITE, 16'h50c7, 8'hff, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_IDLE, 16'h4000, 8'h00, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_READ, 16'hffff, 8'h00, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_WRITE, ADDR_IRQ_EN, 8'h00, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_TICK, 16'h0000, 8'h00, 8'h00, 7'h00, 4'h0);
    wait_drain();

    apply_dip(8'hff);
    repeat (300) access_queue.push_back(random_access(1'b0));
    wait_drain();

    // The receiver holds off for a long stretch here so the block backs up into its input.
    apply_dip(8'($urandom));
    repeat (250) access_queue.push_back(random_access(1'b0));
    hold_request = 1'b1;
    wait_drain();

    // A long run of ticks advances the mystery clock with interrupts enabled.
    apply_dip(8'h00);
    queue_access(ACT_WRITE, ADDR_DIP, 8'h03, 8'h00, 7'h00, 4'h0);
    queue_access(ACT_WRITE, ADDR_IRQ_EN, 8'h01, 8'h00, 7'h00, 4'h0);
    repeat (400) access_queue.push_back(random_access(1'b1));
    wait_drain();

    apply_dip(8'($urandom));
    repeat (170) access_queue.push_back(random_access(1'b0));
    wait_drain();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      offered <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(decode_access(offered));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (access_queue.size() > 0) begin
          offered <= access_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  logic [15:0] ready_pattern = '1;
  logic [3:0] pattern_pos = '0;
  int unsigned hold_left = 0;
  bit hold_taken = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      ready_pattern <= '1;
      pattern_pos <= '0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HoldOffCycles;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (pattern_pos == '0)
        ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
      pattern_pos <= pattern_pos + 4'd1;
      out_ready <= ready_pattern[pattern_pos];
    end
  end

  always @(posedge clk_i) begin : result_check
    bus_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MaxReports)
          $display("unexpected result: rd=%h irq=%b flip=%b shown=%b clk=%0d snd=%b/%0d/%h",
                   observed.read_data, observed.irq_request, observed.flip_state,
                   observed.clock_shown, observed.clock_value, observed.sound_written,
                   observed.sound_index, observed.sound_value);
      end else begin
        want = expected_results.pop_front();
        if (observed !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < MaxReports)
            $display({"mismatch: expected rd=%h irq=%b flip=%b shown=%b clk=%0d snd=%b/%0d/%h",
                      " actual rd=%h irq=%b flip=%b shown=%b clk=%0d snd=%b/%0d/%h"},
                     want.read_data, want.irq_request, want.flip_state, want.clock_shown,
                     want.clock_value, want.sound_written, want.sound_index,
                     want.sound_value, observed.read_data, observed.irq_request,
                     observed.flip_state, observed.clock_shown, observed.clock_value,
                     observed.sound_written, observed.sound_index, observed.sound_value);
        end
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
